### design/sts_pkg.sv
package sts_pkg;

    // Fixed field widths of the request and result items.
    localparam int KEY_W = 32;
    localparam int IDX_W = 10;
    localparam int POS_W = 11;
    localparam int CNT_W = 11;

    // Kind of an input request, carried in tuser.
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // Which of the two halving searches the shared step unit is serving.
    typedef enum logic [0:0] {
        PH_CLASSIC = 1'b0,
        PH_LOWER   = 1'b1
    } t_phase;

    // Decision flags of one halving step.
    typedef struct packed {
        logic less;
        logic hit;
        logic done;
    } t_step_flags;

endpackage

### design/sts_ram.sv
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sts_step_unit.sv
module sts_step_unit #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  sts_pkg::t_phase                  i_phase,
    input  logic [CW-1:0]                    i_lo,
    input  logic [CW-1:0]                    i_hi,
    input  logic [AW-1:0]                    i_mid,
    input  logic signed [sts_pkg::KEY_W-1:0] i_entry,
    input  logic signed [sts_pkg::KEY_W-1:0] i_key,
    output sts_pkg::t_step_flags             o_flags,
    output logic [CW-1:0]                    o_next_lo,
    output logic [CW-1:0]                    o_next_hi,
    output logic [AW-1:0]                    o_next_mid
);

    logic          less;
    logic          greater;
    logic [CW-1:0] next_lo;
    logic [CW-1:0] next_hi;
    logic [CW:0]   sum;
    logic [CW:0]   mid_wide;

    // Signed compare of the entry read for the current midpoint against the key.
    assign less    = i_entry < i_key;
    assign greater = i_key < i_entry;

    // Narrow the bounds; the half-open range [lo, hi) stands for both searches.
    always_comb begin
        next_lo = i_lo;
        next_hi = i_hi;
        if (less) begin
            next_lo = CW'(i_mid) + CW'(1);
        end else if (greater || (i_phase == sts_pkg::PH_LOWER)) begin
            next_hi = CW'(i_mid);
        end
    end

    // The classic search uses floor((left + right) / 2) with right = hi - 1.
    // Only meaningful while the range is not empty, so the sum is at least one.
    assign sum = {1'b0, next_lo} + {1'b0, next_hi};
    always_comb begin
        if (i_phase == sts_pkg::PH_CLASSIC) begin
            mid_wide = (sum - (CW + 1)'(1)) >> 1;
        end else begin
            mid_wide = sum >> 1;
        end
    end

    assign o_flags.less = less;
    assign o_flags.hit  = (i_phase == sts_pkg::PH_CLASSIC) && !less && !greater;
    assign o_flags.done = o_flags.hit || (next_lo >= next_hi);
    assign o_next_lo    = next_lo;
    assign o_next_hi    = next_hi;
    assign o_next_mid   = mid_wide[AW-1:0];

endmodule

### design/sorted_table_binary_search.sv
// Channel   | Direction | Handshake                     | Contents
// ----------+-----------+-------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | load or search request
// m_axis    | out       | m_axis_tvalid / m_axis_tready | search result
// cfg       | in        | i_cfg_valid / o_cfg_ready     | entry_count register
//
// A load request writes the table directly and the block stays ready for the next one.
// A search runs as a start, the halving steps of the classic search and then of
// the lower-bound search, each step being one read of the table RAM and one
// compare in the shared step unit, and a hand-over of the result.
// Reset clears the control state and entry_count; the table is not cleared.
// A result waits in the output register while the next request is taken; a
// search that finishes while that register is still full holds until it drains.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [9:0] entry_index, [41:10] item_value, [47:42] zero
    input  logic [47:0]               s_axis_tdata,
    // [0] op
    input  logic [0:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [9:0] match_index, [20:10] insert_position, [23:21] zero
    output logic [23:0]               m_axis_tdata,
    // [0] found
    output logic [0:0]                m_axis_tuser,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sts_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam int          CW      = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned DEPTH_U = TABLE_DEPTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIC,
        ST_LOWER,
        ST_FINISH
    } t_state;

    t_state                            r_state, n_state;
    logic [sts_pkg::CNT_W-1:0]         r_count;
    logic [CW-1:0]                     r_n, n_n;
    logic [CW-1:0]                     r_lo, n_lo;
    logic [CW-1:0]                     r_hi, n_hi;
    logic [AW-1:0]                     r_mid, n_mid;
    logic signed [sts_pkg::KEY_W-1:0]  r_key, n_key;
    logic                              r_found, n_found;
    logic [AW-1:0]                     r_match, n_match;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_found, n_out_found;
    logic [sts_pkg::IDX_W-1:0]         r_out_match, n_out_match;
    logic [sts_pkg::POS_W-1:0]         r_out_pos, n_out_pos;

    logic [sts_pkg::IDX_W-1:0]         in_index;
    logic signed [sts_pkg::KEY_W-1:0]  in_value;
    sts_pkg::t_op                      in_op;
    logic                              in_accept;
    logic [CW-1:0]                     count_sat;
    logic                              ram_we;
    logic signed [sts_pkg::KEY_W-1:0]  ram_rdata;
    sts_pkg::t_phase                   phase;
    sts_pkg::t_step_flags              step_flags;
    logic [CW-1:0]                     step_lo;
    logic [CW-1:0]                     step_hi;
    logic [AW-1:0]                     step_mid;

    // Unpack the request.
    assign in_index  = s_axis_tdata[sts_pkg::IDX_W-1:0];
    assign in_value  = s_axis_tdata[sts_pkg::IDX_W +: sts_pkg::KEY_W];
    assign in_op     = sts_pkg::t_op'(s_axis_tuser[0]);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Always ready; write the register only while idle; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    // Number of searched entries, saturated to the table depth.
    assign count_sat = (32'(r_count) > DEPTH_U) ? CW'(TABLE_DEPTH) : CW'(r_count);

    // A load writes the table straight from the request; out-of-range loads are dropped.
    assign ram_we = in_accept && (in_op == sts_pkg::OP_LOAD) && (32'(in_index) < DEPTH_U);

    sts_ram #(
        .WIDTH (sts_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_index)),
        .i_wdata (in_value),
        .i_raddr (n_mid),
        .o_rdata (ram_rdata)
    );

    assign phase = (r_state == ST_LOWER) ? sts_pkg::PH_LOWER : sts_pkg::PH_CLASSIC;

    sts_step_unit #(
        .AW (AW),
        .CW (CW)
    ) u_step (
        .i_phase    (phase),
        .i_lo       (r_lo),
        .i_hi       (r_hi),
        .i_mid      (r_mid),
        .i_entry    (ram_rdata),
        .i_key      (r_key),
        .o_flags    (step_flags),
        .o_next_lo  (step_lo),
        .o_next_hi  (step_hi),
        .o_next_mid (step_mid)
    );

    // Sequencer: start, classic halving steps, lower-bound steps, hand-over.
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_found     = r_found;
        n_match     = r_match;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_match = r_out_match;
        n_out_pos   = r_out_pos;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (in_op == sts_pkg::OP_SEARCH)) begin
                    n_key   = in_value;
                    n_n     = count_sat;
                    n_found = 1'b0;
                    n_match = '0;
                    n_lo    = '0;
                    n_hi    = count_sat;
                    if (count_sat == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_mid   = AW'((count_sat - CW'(1)) >> 1);
                        n_state = ST_CLASSIC;
                    end
                end
            end
            ST_CLASSIC: begin
                if (step_flags.done) begin
                    if (step_flags.hit) begin
                        n_found = 1'b1;
                        n_match = r_mid;
                    end
                    n_lo    = '0;
                    n_hi    = r_n;
                    n_mid   = AW'(r_n >> 1);
                    n_state = ST_LOWER;
                end else begin
                    n_lo  = step_lo;
                    n_hi  = step_hi;
                    n_mid = step_mid;
                end
            end
            ST_LOWER: begin
                n_lo = step_lo;
                n_hi = step_hi;
                if (step_flags.done) begin
                    n_state = ST_FINISH;
                end else begin
                    n_mid = step_mid;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_match = sts_pkg::IDX_W'(r_match);
                    n_out_pos   = sts_pkg::POS_W'(r_lo);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
        r_n         <= n_n;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_found     <= n_found;
        r_match     <= n_match;
        r_out_found <= n_out_found;
        r_out_match <= n_out_match;
        r_out_pos   <= n_out_pos;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pos, r_out_match};
    assign m_axis_tuser  = r_out_found;

    // While a halving step runs, the range is not empty and the midpoint lies in it.
    a_range_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLASSIC || r_state == ST_LOWER) |-> (r_lo < r_hi))
        else $error("halving step entered with an empty range");

    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLASSIC || r_state == ST_LOWER) |->
        ((CW'(r_mid) >= r_lo) && (CW'(r_mid) < r_hi)))
        else $error("midpoint outside the search range");

    a_hi_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ((r_hi <= r_n) && (r_n <= CW'(TABLE_DEPTH))))
        else $error("upper bound beyond the searched entries");

    a_match_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_found) |-> (CW'(r_match) < r_n))
        else $error("match index beyond the searched entries");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == ST_FINISH))
        else $error("result raised outside the hand-over state");

endmodule
